// ===== rtl/jkve_pkg.sv =====
`timescale 1ns / 1ps

package jkve_pkg;

  // build defaults handed to the top level parameters
  localparam int KEY_BYTES_DEF = 16;
  localparam int MAX_DEPTH_DEF = 255;

  // key characters held in the two key registers
  localparam int KEY_REG_CHARS = 16;
  localparam int KEY_IDX_W     = 4;

  // result queue depth, a power of two of at least two
  localparam int RES_FIFO_DEPTH = 4;

  // input transaction codes
  localparam logic ACT_TEXT = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // result kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // final status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_KEY_ABSENT = 3'd1;
  localparam logic [2:0] ST_WRONG_TYPE = 3'd2;
  localparam logic [2:0] ST_UNTERM     = 3'd3;
  localparam logic [2:0] ST_TOO_BIG    = 3'd4;
  localparam logic [2:0] ST_DEPTH_OVF  = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_KEY_LOW  = 3'd0;
  localparam logic [2:0] REG_KEY_HIGH = 3'd1;
  localparam logic [2:0] REG_KEY_LEN  = 3'd2;
  localparam logic [2:0] REG_MODE     = 3'd3;
  localparam logic [2:0] REG_CAPACITY = 3'd4;

  // value modes
  localparam logic MODE_STRING = 1'b0;

  // characters
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;

  typedef struct packed {
    logic       action;
    logic [7:0] text_byte;
  } text_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] value_byte;
    logic [2:0] status;
    logic       last;
  } result_item_t;

  // up to two results pushed per processed transaction
  typedef struct packed {
    logic [1:0]   count;
    result_item_t first;
    result_item_t second;
  } result_push_t;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_AFTER_KEY,
    PH_AFTER_COLON,
    PH_STRING,
    PH_BLOCK,
    PH_DONE
  } phase_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic result_item_t byte_item(input logic [7:0] b);
    result_item_t r;
    r.kind       = KIND_BYTE;
    r.value_byte = b;
    r.status     = ST_OK;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic result_item_t status_item(input logic [2:0] st);
    result_item_t r;
    r.kind       = KIND_STATUS;
    r.value_byte = 8'h00;
    r.status     = st;
    r.last       = 1'b1;
    return r;
  endfunction

endpackage

// ===== rtl/jkve_key_match.sv =====
`timescale 1ns / 1ps

module jkve_key_match import jkve_pkg::*; #(
  parameter int KEY_BYTES = KEY_BYTES_DEF,
  localparam int WIN      = KEY_BYTES + 2,
  localparam int FILL_W   = $clog2(WIN + 1)
) (
  input  logic [8*WIN-1:0]         window,
  input  logic [FILL_W-1:0]        fill,
  input  logic [8*KEY_REG_CHARS-1:0] key_chars,
  input  logic [4:0]               key_length,
  output logic                     match
);

  logic [7:0] key_ch [KEY_REG_CHARS];

  // split the key registers into characters
  always_comb begin
    for (int i = 0; i < KEY_REG_CHARS; i++) begin
      key_ch[i] = key_chars[8*i +: 8];
    end
  end

  // window holds the newest byte at position 0, so the key reads backwards
  always_comb begin
    int         kidx;
    logic [7:0] kc;
    logic       ok;
    ok   = 1'b1;
    kidx = 0;
    kc   = 8'h00;
    if ((int'(key_length) > KEY_BYTES) || (int'(fill) < int'(key_length) + 2)) begin
      ok = 1'b0;
    end
    if (window[7:0] != CH_QUOTE) begin
      ok = 1'b0;
    end
    for (int p = 1; p < WIN; p++) begin
      if ((p == int'(key_length) + 1) && (window[8*p +: 8] != CH_QUOTE)) begin
        ok = 1'b0;
      end
      if (p <= int'(key_length)) begin
        kidx = int'(key_length) - p;
        if (kidx < KEY_REG_CHARS) begin
          kc = key_ch[kidx[KEY_IDX_W-1:0]];
        end else begin
          kc = 8'h00;
        end
        if (window[8*p +: 8] != kc) begin
          ok = 1'b0;
        end
      end
    end
    match = ok;
  end

endmodule

// ===== rtl/jkve_result_fifo.sv =====
`timescale 1ns / 1ps

module jkve_result_fifo import jkve_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  result_push_t push,
  output logic         room,
  output logic         out_valid,
  input  logic         out_stall,
  output result_item_t out_item
);

  localparam int DEPTH = RES_FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_item_t     mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != '0);
  assign out_item  = mem[rptr];
  // space for a full pair of results
  assign room      = (count <= CNT_W'(DEPTH - 2));

  always_comb begin
    count_next = count + CNT_W'(push.count) - CNT_W'(pop);
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PTR_W'(push.count);
      rptr  <= rptr + PTR_W'(pop);
      count <= count_next;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wptr + PTR_W'(1)] <= push.second;
    end
  end

endmodule

// ===== rtl/json_key_value_extractor_top.sv =====
`timescale 1ns / 1ps

// Streaming JSON key/value extractor. Text enters one byte per transaction on the
// text channel; the block finds the first quoted key equal to the configured key
// that is followed by optional whitespace and a colon, then either emits the
// following string value with escapes decoded (value_mode 0) or copies the
// following balanced object or array verbatim (value_mode 1). Each extraction
// ends with one status result marked last; an end-of-text transaction closes the
// extraction and rearms the search. Throughput is one text byte per clock: each
// byte is held in the input register and is resolved in one pass of the
// window compare and value logic into a four-entry result queue, so the byte
// rate is limited only by how fast the result side drains (two results at most
// per byte, only on the closing bracket, on the byte that fills a string value
// to capacity, or on a pending escape at end of text).
// Results pass the input register and then the result queue. The user must write
// configuration while the block is idle (not enforced); it takes effect at once.

module json_key_value_extractor_top import jkve_pkg::*; #(
  parameter int KEY_BYTES = KEY_BYTES_DEF,
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // text channel
  input  logic         text_valid,
  output logic         text_stall,
  input  text_item_t   text_item,
  // result channel
  output logic         result_valid,
  input  logic         result_stall,
  output result_item_t result_item,
  // configuration write channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  localparam int WIN     = KEY_BYTES + 2;
  localparam int FILL_W  = $clog2(WIN + 1);
  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

  // configuration registers
  logic [63:0] key_low;
  logic [63:0] key_high;
  logic [4:0]  key_length;
  logic        value_mode;
  logic [15:0] capacity;

  // input register
  logic       in_full;
  text_item_t in_reg;
  logic       accept;
  logic       proc;
  logic       room;

  // search and value state
  logic [7:0]         recent [WIN];
  logic [7:0]         recent_next [WIN];
  logic [FILL_W-1:0]  fill;
  logic [FILL_W-1:0]  fill_next;
  logic [FILL_W-1:0]  fill_inc;
  phase_t             phase;
  phase_t             phase_next;
  logic               esc;
  logic               esc_next;
  logic               inq;
  logic               inq_next;
  logic [DEPTH_W-1:0] depth;
  logic [DEPTH_W-1:0] depth_next;
  logic [15:0]        emitted;
  logic [15:0]        emitted_next;
  logic               opener;
  logic               opener_next;

  // per byte decode
  logic [7:0]       c;
  logic             ws;
  logic [8*WIN-1:0] win_new;
  logic             match;
  logic             blk_full;
  logic             str_full;
  logic             cap_zero;
  logic             cap_le1;
  logic [7:0]       blk_open;
  logic [7:0]       blk_close;
  logic             depth_at_max;
  logic [7:0]       str_byte;
  result_push_t     push;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low    <= '0;
      key_high   <= '0;
      key_length <= '0;
      value_mode <= MODE_STRING;
      capacity   <= 16'd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY_LOW:  key_low    <= cfg_data;
        REG_KEY_HIGH: key_high   <= cfg_data;
        REG_KEY_LEN:  key_length <= cfg_data[4:0];
        REG_MODE:     value_mode <= cfg_data[0];
        REG_CAPACITY: capacity   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input register, refilled in the cycle it drains
  assign proc       = in_full && room;
  assign text_stall = in_full && !room;
  assign accept     = text_valid && !text_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (proc) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg <= text_item;
    end
  end

  // shared decode of the byte under work
  assign c            = in_reg.text_byte;
  assign ws           = is_ws(c);
  assign fill_inc     = (int'(fill) < WIN) ? fill + FILL_W'(1) : fill;
  assign blk_full     = ({1'b0, emitted} + 17'd1) >= {1'b0, capacity};
  assign str_full     = ({1'b0, emitted} + 17'd2) >= {1'b0, capacity};
  assign cap_zero     = (capacity == 16'd0);
  assign cap_le1      = (capacity <= 16'd1);
  assign blk_open     = opener ? CH_LBRACKET : CH_LBRACE;
  assign blk_close    = opener ? CH_RBRACKET : CH_RBRACE;
  assign depth_at_max = (depth >= DEPTH_W'(MAX_DEPTH));

  // shifted window with the new byte at the front
  always_comb begin
    win_new[7:0] = c;
    for (int k = 1; k < WIN; k++) begin
      win_new[8*k +: 8] = recent[k-1];
    end
  end

  jkve_key_match #(
    .KEY_BYTES (KEY_BYTES)
  ) u_key_match (
    .window     (win_new),
    .fill       (fill_inc),
    .key_chars  ({key_high, key_low}),
    .key_length (key_length),
    .match      (match)
  );

  // escape decode in string values
  always_comb begin
    str_byte = c;
    if (esc) begin
      if (c == CH_N) begin
        str_byte = CH_LF;
      end else if (c == CH_T) begin
        str_byte = CH_TAB;
      end else if (c == CH_R) begin
        str_byte = CH_CR;
      end
    end
  end

  // next state
  always_comb begin
    recent_next  = recent;
    fill_next    = fill;
    phase_next   = phase;
    esc_next     = esc;
    inq_next     = inq;
    depth_next   = depth;
    emitted_next = emitted;
    opener_next  = opener;
    if (proc) begin
      if (in_reg.action == ACT_END) begin
        for (int k = 0; k < WIN; k++) begin
          recent_next[k] = 8'h00;
        end
        fill_next    = '0;
        phase_next   = PH_SEARCH;
        esc_next     = 1'b0;
        inq_next     = 1'b0;
        depth_next   = '0;
        emitted_next = '0;
        opener_next  = 1'b0;
      end else begin
        unique case (phase)
          PH_SEARCH, PH_AFTER_KEY: begin
            for (int k = 0; k < WIN; k++) begin
              recent_next[k] = win_new[8*k +: 8];
            end
            fill_next = fill_inc;
            if ((phase == PH_AFTER_KEY) && ws) begin
              phase_next = PH_AFTER_KEY;
            end else if ((phase == PH_AFTER_KEY) && (c == CH_COLON)) begin
              phase_next = PH_AFTER_COLON;
            end else if (match) begin
              phase_next = PH_AFTER_KEY;
              fill_next  = '0;
            end else begin
              phase_next = PH_SEARCH;
            end
          end
          PH_AFTER_COLON: begin
            if (!ws) begin
              if (cap_zero) begin
                phase_next = PH_DONE;
              end else if (value_mode == MODE_STRING) begin
                if ((c != CH_QUOTE) || cap_le1) begin
                  phase_next = PH_DONE;
                end else begin
                  phase_next = PH_STRING;
                end
              end else if ((c != CH_LBRACE) && (c != CH_LBRACKET)) begin
                phase_next = PH_DONE;
              end else begin
                opener_next = (c == CH_LBRACKET);
                if (cap_le1) begin
                  phase_next = PH_DONE;
                end else begin
                  phase_next   = PH_BLOCK;
                  depth_next   = DEPTH_W'(1);
                  emitted_next = 16'd1;
                end
              end
            end
          end
          PH_STRING: begin
            if (esc) begin
              esc_next     = 1'b0;
              emitted_next = emitted + 16'd1;
              if (str_full) begin
                phase_next = PH_DONE;
              end
            end else if (c == CH_BACKSLASH) begin
              esc_next = 1'b1;
            end else if (c == CH_QUOTE) begin
              phase_next = PH_DONE;
            end else begin
              emitted_next = emitted + 16'd1;
              if (str_full) begin
                phase_next = PH_DONE;
              end
            end
          end
          PH_BLOCK: begin
            if (blk_full) begin
              phase_next = PH_DONE;
            end else if (esc) begin
              esc_next     = 1'b0;
              emitted_next = emitted + 16'd1;
            end else if (inq) begin
              if (c == CH_BACKSLASH) begin
                esc_next = 1'b1;
              end else if (c == CH_QUOTE) begin
                inq_next = 1'b0;
              end
              emitted_next = emitted + 16'd1;
            end else if (c == CH_QUOTE) begin
              inq_next     = 1'b1;
              emitted_next = emitted + 16'd1;
            end else if (c == blk_open) begin
              if (depth_at_max) begin
                phase_next = PH_DONE;
              end else begin
                depth_next   = depth + DEPTH_W'(1);
                emitted_next = emitted + 16'd1;
              end
            end else if (c == blk_close) begin
              depth_next   = depth - DEPTH_W'(1);
              emitted_next = emitted + 16'd1;
              if (depth == DEPTH_W'(1)) begin
                phase_next = PH_DONE;
              end
            end else begin
              emitted_next = emitted + 16'd1;
            end
          end
          PH_DONE: ;
          default: ;
        endcase
      end
    end
  end

  // results of the byte under work
  always_comb begin
    push.count  = 2'd0;
    push.first  = status_item(ST_OK);
    push.second = status_item(ST_OK);
    if (proc) begin
      if (in_reg.action == ACT_END) begin
        unique case (phase)
          PH_SEARCH, PH_AFTER_KEY: begin
            push.count = 2'd1;
            push.first = status_item(ST_KEY_ABSENT);
          end
          PH_AFTER_COLON: begin
            push.count = 2'd1;
            push.first = status_item(ST_WRONG_TYPE);
          end
          PH_STRING: begin
            if (esc) begin
              push.count  = 2'd2;
              push.first  = byte_item(CH_BACKSLASH);
              push.second = status_item(ST_OK);
            end else begin
              push.count = 2'd1;
              push.first = status_item(ST_OK);
            end
          end
          PH_BLOCK: begin
            push.count = 2'd1;
            push.first = status_item(ST_UNTERM);
          end
          PH_DONE: ;
          default: ;
        endcase
      end else begin
        unique case (phase)
          PH_SEARCH, PH_AFTER_KEY: ;
          PH_AFTER_COLON: begin
            if (!ws) begin
              push.count = 2'd1;
              if (cap_zero) begin
                push.first = status_item(ST_TOO_BIG);
              end else if (value_mode == MODE_STRING) begin
                if (c != CH_QUOTE) begin
                  push.first = status_item(ST_WRONG_TYPE);
                end else if (cap_le1) begin
                  push.first = status_item(ST_OK);
                end else begin
                  push.count = 2'd0;
                end
              end else if ((c != CH_LBRACE) && (c != CH_LBRACKET)) begin
                push.first = status_item(ST_WRONG_TYPE);
              end else if (cap_le1) begin
                push.first = status_item(ST_TOO_BIG);
              end else begin
                push.first = byte_item(c);
              end
            end
          end
          PH_STRING: begin
            if (esc || ((c != CH_BACKSLASH) && (c != CH_QUOTE))) begin
              push.first = byte_item(str_byte);
              if (str_full) begin
                push.count  = 2'd2;
                push.second = status_item(ST_OK);
              end else begin
                push.count = 2'd1;
              end
            end else if (c == CH_QUOTE) begin
              push.count = 2'd1;
              push.first = status_item(ST_OK);
            end
          end
          PH_BLOCK: begin
            push.count = 2'd1;
            push.first = byte_item(c);
            if (blk_full) begin
              push.first = status_item(ST_TOO_BIG);
            end else if (!esc && !inq && (c == blk_open) && depth_at_max) begin
              push.first = status_item(ST_DEPTH_OVF);
            end else if (!esc && !inq && (c == blk_close) && (depth == DEPTH_W'(1))) begin
              push.count  = 2'd2;
              push.second = status_item(ST_OK);
            end
          end
          PH_DONE: ;
          default: ;
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WIN; k++) begin
        recent[k] <= 8'h00;
      end
      fill    <= '0;
      phase   <= PH_SEARCH;
      esc     <= 1'b0;
      inq     <= 1'b0;
      depth   <= '0;
      emitted <= '0;
      opener  <= 1'b0;
    end else begin
      recent  <= recent_next;
      fill    <= fill_next;
      phase   <= phase_next;
      esc     <= esc_next;
      inq     <= inq_next;
      depth   <= depth_next;
      emitted <= emitted_next;
      opener  <= opener_next;
    end
  end

  jkve_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_item  (result_item)
  );

  // end of text always rearms the search
  assert property (@(posedge clk) disable iff (rst)
    proc && (in_reg.action == ACT_END) |=> (phase == PH_SEARCH) && (fill == '0))
    else $error("search not rearmed after end of text");

  // a finished extraction ignores further text
  assert property (@(posedge clk) disable iff (rst)
    proc && (phase == PH_DONE) && (in_reg.action == ACT_TEXT) |-> (push.count == 2'd0))
    else $error("result pushed after final status");

  // nesting is only tracked while a block is open or after the extraction has ended
  assert property (@(posedge clk) disable iff (rst)
    (phase != PH_BLOCK) && (phase != PH_DONE) |-> (depth == '0))
    else $error("nesting depth outside a block");

  // every pushed status result closes the extraction
  assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) && (push.first.kind == KIND_STATUS) |=> (phase == PH_DONE)
      || (phase == PH_SEARCH))
    else $error("status pushed without ending the extraction");

endmodule
